// File: design/bfiq_pkg.sv
// Shared types and constants for the bloom filter insert/query block.
`default_nettype none

package bfiq_pkg;

    // Default geometry
    localparam int STORE_BITS_LOG2_DEF = 16;
    localparam int MAX_HASHES_DEF      = 8;

    // Store word layout
    localparam int WORD_BITS     = 64;
    localparam int WORD_SEL_BITS = 6;
    localparam int BYTE_BITS     = 8;
    localparam int SLICE_BITS    = 16;
    localparam int HASH_BITS     = 128;

    // Field and register widths
    localparam int IDX_W_BITS     = 5;
    localparam int HCNT_BITS      = 4;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 5;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_WIDTH = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HASH_COUNT  = 4'd1;

    // Register reset values and limits
    localparam logic [IDX_W_BITS-1:0] RESET_INDEX_WIDTH = 5'd16;
    localparam logic [HCNT_BITS-1:0]  RESET_HASH_COUNT  = 4'd4;
    localparam logic [IDX_W_BITS-1:0] MIN_INDEX_WIDTH   = 5'd8;

    // Request modes
    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Per-request control carried from front to back
    typedef struct packed {
        logic                 mode;
        logic [HCNT_BITS-1:0] count;
    } bfiq_ctl_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic pop;
        logic clr_busy;
    } bfiq_back_stat_t;

endpackage

`default_nettype wire

// File: design/bfiq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bfiq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];  // read-first
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/bfiq_front.sv
// Front end: clamps config, slices the hash into bit indexes, queues requests.
`default_nettype none

module bfiq_front
    import bfiq_pkg::*;
#(
    parameter int STORE_BITS_LOG2 = STORE_BITS_LOG2_DEF,
    parameter int MAX_HASHES      = MAX_HASHES_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        push,
    output logic                                             full,
    input  wire logic                                        mode,
    input  wire logic [63:0]                                 hash_low,
    input  wire logic [63:0]                                 hash_high,
    input  wire logic [IDX_W_BITS-1:0]                       index_width,
    input  wire logic [HCNT_BITS-1:0]                        hash_count,
    input  wire bfiq_back_stat_t                             stat,
    output logic                                             head_valid,
    output bfiq_ctl_t                                        head_ctl,
    output logic [MAX_HASHES-1:0][STORE_BITS_LOG2-1:0]       head_idx
);

    localparam int QDEPTH = 2;

    logic [HASH_BITS-1:0]                          stream;
    logic [IDX_W_BITS-1:0]                         w_eff;
    logic [HCNT_BITS-1:0]                          n_eff;
    logic [SLICE_BITS-1:0]                         wmask;
    logic [SLICE_BITS-1:0]                         slice;
    logic [MAX_HASHES-1:0][STORE_BITS_LOG2-1:0]    new_idx;
    bfiq_ctl_t                                     new_ctl;
    logic                                          push_ok;

    bfiq_ctl_t                                     ctl_mem_reg [QDEPTH];
    logic [MAX_HASHES-1:0][STORE_BITS_LOG2-1:0]    idx_mem_reg [QDEPTH];
    logic                                          wr_ptr_reg, wr_ptr_next;
    logic                                          rd_ptr_reg, rd_ptr_next;
    logic [1:0]                                    q_count_reg, q_count_next;

    // Clamp the registers into their working ranges
    always_comb
    begin
        if (index_width < MIN_INDEX_WIDTH)
        begin
            w_eff = MIN_INDEX_WIDTH;
        end
        else if (index_width > IDX_W_BITS'(STORE_BITS_LOG2))
        begin
            w_eff = IDX_W_BITS'(STORE_BITS_LOG2);
        end
        else
        begin
            w_eff = index_width;
        end

        if (hash_count == '0)
        begin
            n_eff = HCNT_BITS'(1);
        end
        else if (hash_count > HCNT_BITS'(MAX_HASHES))
        begin
            n_eff = HCNT_BITS'(MAX_HASHES);
        end
        else
        begin
            n_eff = hash_count;
        end
    end

    assign stream = {hash_high, hash_low};
    assign wmask  = ~({SLICE_BITS{1'b1}} << w_eff);

    // One-byte slices at the minimum width, two-byte slices (first byte high) above it
    always_comb
    begin
        slice   = '0;
        new_idx = '0;
        for (int i = 0; i < MAX_HASHES; i++)
        begin
            if (w_eff == MIN_INDEX_WIDTH)
            begin
                slice = {{BYTE_BITS{1'b0}}, stream[BYTE_BITS*i +: BYTE_BITS]};
            end
            else
            begin
                slice = {stream[2*BYTE_BITS*i +: BYTE_BITS],
                         stream[2*BYTE_BITS*i + BYTE_BITS +: BYTE_BITS]};
            end
            slice      = slice & wmask;
            new_idx[i] = slice[STORE_BITS_LOG2-1:0];
        end
    end

    assign new_ctl.mode  = mode;
    assign new_ctl.count = n_eff;

    assign full    = (q_count_reg == 2'(QDEPTH)) || stat.clr_busy;
    assign push_ok = push && !full;

    always_comb
    begin
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        q_count_next = q_count_reg;
        if (push_ok)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (stat.pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push_ok && !stat.pop)
        begin
            q_count_next = q_count_reg + 2'd1;
        end
        else if (!push_ok && stat.pop)
        begin
            q_count_next = q_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            q_count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            ctl_mem_reg[wr_ptr_reg] <= new_ctl;
            idx_mem_reg[wr_ptr_reg] <= new_idx;
        end
    end

    assign head_valid = (q_count_reg != 2'd0);
    assign head_ctl   = ctl_mem_reg[rd_ptr_reg];
    assign head_idx   = idx_mem_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= 2'(QDEPTH))
        else $error("request queue over depth");

    a_q_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count_reg == 2'd0 && push_ok) |=> head_valid)
        else $error("accepted request not visible at queue head");
`endif

endmodule

`default_nettype wire

// File: design/bfiq_back.sv
// Back end: one store probe per cycle unless stalled; RMW, clear pass, result queue.
`default_nettype none

module bfiq_back
    import bfiq_pkg::*;
#(
    parameter int STORE_BITS_LOG2 = STORE_BITS_LOG2_DEF,
    parameter int MAX_HASHES      = MAX_HASHES_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     head_valid,
    input  wire bfiq_ctl_t                                head_ctl,
    input  wire logic [MAX_HASHES-1:0][STORE_BITS_LOG2-1:0] head_idx,
    output bfiq_back_stat_t                               stat,
    output logic                                          empty,
    input  wire logic                                     pop,
    output logic                                          maybe_present
);

    localparam int ADDR_W = STORE_BITS_LOG2 - WORD_SEL_BITS;
    localparam int WORDS  = 1 << ADDR_W;
    localparam int PC_W   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int RDEPTH = 2;

    // Issue stage
    logic [PC_W-1:0]            probe_cnt_reg, probe_cnt_next;
    logic [STORE_BITS_LOG2-1:0] issue_idx;
    logic                       issue_last;
    logic                       issue;
    logic                       res_pending;
    logic                       res_room;

    // Data stage
    logic                       s1_valid_reg;
    logic                       s1_mode_reg;
    logic                       s1_last_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic [WORD_SEL_BITS-1:0]   s1_bit_reg;
    logic [WORD_BITS-1:0]       rd_data;
    logic [WORD_BITS-1:0]       eff_word;
    logic [WORD_BITS-1:0]       new_word;
    logic                       hit;
    logic                       add_wr;
    logic                       acc_reg, acc_next;

    // Bypass of the word written in the previous cycle
    logic                       fwd_valid_reg;
    logic [ADDR_W-1:0]          fwd_addr_reg;
    logic [WORD_BITS-1:0]       fwd_data_reg;

    // Clear pass
    logic                       clr_busy_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;

    // RAM ports
    logic                       ram_wr_en;
    logic [ADDR_W-1:0]          ram_wr_addr;
    logic [WORD_BITS-1:0]       ram_wr_data;

    // Result queue
    logic                       res_mem_reg [RDEPTH];
    logic                       res_wr_ptr_reg;
    logic                       res_rd_ptr_reg;
    logic [1:0]                 res_count_reg, res_count_next;
    logic                       res_push;
    logic                       res_pop;
    logic                       res_bit;

    assign issue_idx  = head_idx[probe_cnt_reg];
    assign issue_last = (({{(HCNT_BITS-PC_W){1'b0}}, probe_cnt_reg} + HCNT_BITS'(1))
                         == head_ctl.count);

    assign res_pending = s1_valid_reg && s1_last_reg && (s1_mode_reg == MODE_QUERY);
    assign res_room    = (res_count_reg == 2'd0) || ((res_count_reg == 2'd1) && !res_pending);

    // A query's last probe waits for a free result slot
    assign issue = head_valid && !clr_busy_reg &&
                   (!(issue_last && (head_ctl.mode == MODE_QUERY)) || res_room);

    assign stat.pop      = issue && issue_last;
    assign stat.clr_busy = clr_busy_reg;

    always_comb
    begin
        probe_cnt_next = probe_cnt_reg;
        if (issue)
        begin
            probe_cnt_next = issue_last ? '0 : probe_cnt_reg + PC_W'(1);
        end
    end

    bfiq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issue),
        .rd_addr (issue_idx[STORE_BITS_LOG2-1:WORD_SEL_BITS]),
        .rd_data (rd_data)
    );

    assign eff_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;
    assign hit      = eff_word[s1_bit_reg];
    assign new_word = eff_word | (WORD_BITS'(1) << s1_bit_reg);
    assign add_wr   = s1_valid_reg && (s1_mode_reg == MODE_ADD);

    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en   = add_wr;
            ram_wr_addr = s1_addr_reg;
            ram_wr_data = new_word;
        end
    end

    assign res_bit  = acc_reg && hit;
    assign res_push = res_pending;

    always_comb
    begin
        acc_next = acc_reg;
        if (s1_valid_reg && (s1_mode_reg == MODE_QUERY))
        begin
            acc_next = s1_last_reg ? 1'b1 : res_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            acc_reg       <= 1'b1;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
        end
        else
        begin
            probe_cnt_reg <= probe_cnt_next;
            s1_valid_reg  <= issue;
            fwd_valid_reg <= add_wr;
            acc_reg       <= acc_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(WORDS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg  <= head_ctl.mode;
        s1_last_reg  <= issue_last;
        s1_addr_reg  <= issue_idx[STORE_BITS_LOG2-1:WORD_SEL_BITS];
        s1_bit_reg   <= issue_idx[WORD_SEL_BITS-1:0];
        fwd_addr_reg <= s1_addr_reg;
        fwd_data_reg <= new_word;
    end

    // Result queue
    assign res_pop = pop && (res_count_reg != 2'd0);

    always_comb
    begin
        res_count_next = res_count_reg;
        if (res_push && !res_pop)
        begin
            res_count_next = res_count_reg + 2'd1;
        end
        else if (!res_push && res_pop)
        begin
            res_count_next = res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            res_count_reg <= res_count_next;
            if (res_push)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_ptr_reg] <= res_bit;
        end
    end

    assign empty         = (res_count_reg == 2'd0);
    assign maybe_present = res_mem_reg[res_rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_count_reg <= 2'(RDEPTH))
        else $error("result queue over depth");

    a_no_issue_clr: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !issue)
        else $error("probe issued during clear pass");

    a_no_probe_clr: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !clr_busy_reg)
        else $error("probe write collides with clear pass");
`endif

endmodule

`default_nettype wire

// File: design/bloom_filter_insert_query.sv
// Top level of the bloom filter insert/query block.
// Throughput: one store probe per cycle unless held; hash_count (1..8) probes per request.
// A query passes the request queue, the probe issue and data stages, and the result queue.
// Reset: config returns to index_width 16, hash_count 4; then a clear pass zeroes the store
//   one word per cycle over 2^(STORE_BITS_LOG2-6) words (1024 by default), full held high.
// Config writes are always taken (cfg_ready tied high), also during the clear pass.
`default_nettype none

module bloom_filter_insert_query
    import bfiq_pkg::*;
#(
    parameter int STORE_BITS_LOG2 = STORE_BITS_LOG2_DEF,  // 8..16
    parameter int MAX_HASHES      = MAX_HASHES_DEF        // 1..8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // request side
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      mode,
    input  wire logic [63:0]               hash_low,
    input  wire logic [63:0]               hash_high,
    // result side
    output logic                           empty,
    input  wire logic                      pop,
    output logic                           maybe_present,
    // config write channel
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [IDX_W_BITS-1:0]                      index_width_reg;
    logic [HCNT_BITS-1:0]                       hash_count_reg;
    logic                                       head_valid;
    bfiq_ctl_t                                  head_ctl;
    logic [MAX_HASHES-1:0][STORE_BITS_LOG2-1:0] head_idx;
    bfiq_back_stat_t                            back_stat;

    assign cfg_ready = 1'b1;

    // Config registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_width_reg <= RESET_INDEX_WIDTH;
            hash_count_reg  <= RESET_HASH_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INDEX_WIDTH: index_width_reg <= cfg_data[IDX_W_BITS-1:0];
                REG_HASH_COUNT:  hash_count_reg  <= cfg_data[HCNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Front: slices the hash and queues requests
    bfiq_front #(
        .STORE_BITS_LOG2 (STORE_BITS_LOG2),
        .MAX_HASHES      (MAX_HASHES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .hash_low    (hash_low),
        .hash_high   (hash_high),
        .index_width (index_width_reg),
        .hash_count  (hash_count_reg),
        .stat        (back_stat),
        .head_valid  (head_valid),
        .head_ctl    (head_ctl),
        .head_idx    (head_idx)
    );

    // Back: probes the bit store and queues query results
    bfiq_back #(
        .STORE_BITS_LOG2 (STORE_BITS_LOG2),
        .MAX_HASHES      (MAX_HASHES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_ctl      (head_ctl),
        .head_idx      (head_idx),
        .stat          (back_stat),
        .empty         (empty),
        .pop           (pop),
        .maybe_present (maybe_present)
    );

endmodule

`default_nettype wire
